// File: src/cosw_pkg.sv
// ----------------------------------------------------------------------------
// cosw_pkg
// Shared widths, direction codes and turn tables for the spiral walker.
// ----------------------------------------------------------------------------
package cosw_pkg;

  localparam int MAX_ORDER = 63;
  localparam int ORDER_W   = 6;
  localparam int SEQ_W     = 12;
  localparam int SUM_W     = 18;
  localparam int OFF_W     = 8;
  localparam int RING_W    = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ORDER      = 2'd0,
    CFG_START_DIRECTION = 2'd1,
    CFG_ROTATION        = 2'd2
  } cfg_idx_t;

  function automatic dir_t turn_dir(input dir_t h, input logic acw);
    dir_t r;
    r = DIR_RIGHT;
    case (h)
      DIR_RIGHT: r = acw ? DIR_UP    : DIR_DOWN;
      DIR_LEFT:  r = acw ? DIR_DOWN  : DIR_UP;
      DIR_UP:    r = acw ? DIR_LEFT  : DIR_RIGHT;
      DIR_DOWN:  r = acw ? DIR_RIGHT : DIR_LEFT;
      default:   r = DIR_RIGHT;
    endcase
    return r;
  endfunction

  function automatic logic signed [OFF_W-1:0] dir_drow(input dir_t d);
    logic signed [OFF_W-1:0] r;
    r = '0;
    case (d)
      DIR_UP:   r = -OFF_W'(1);
      DIR_DOWN: r = OFF_W'(1);
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [OFF_W-1:0] dir_dcol(input dir_t d);
    logic signed [OFF_W-1:0] r;
    r = '0;
    case (d)
      DIR_RIGHT: r = OFF_W'(1);
      DIR_LEFT:  r = -OFF_W'(1);
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: src/centre_out_spiral_walker.sv
// ----------------------------------------------------------------------------
// centre_out_spiral_walker
// Square spiral scan of an odd n by n grid from the centre outward, with
// running diagonal sum, last-cell flag and even-order error.
// ----------------------------------------------------------------------------
// Pipeline: an item is held in the step register, then in the result register
//   (out_valid high after the second register stage), two register stages in all.
// Throughput: one item per cycle unless held by out_stall; walk state updates in the
//   same cycle that the step register hands its item to the result register.
// Reset: synchronous active-low; clears valids, walk state and the config
//   registers (order 1, start right, clockwise).
module centre_out_spiral_walker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cosw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cosw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cosw_pkg::ORDER_W-1:0]      out_row,
  output logic [cosw_pkg::ORDER_W-1:0]      out_col,
  output logic [cosw_pkg::SEQ_W-1:0]        out_seq_value,
  output logic [cosw_pkg::SUM_W-1:0]        out_diag_sum,
  output logic                              out_last,
  output logic                              out_order_error
);
  import cosw_pkg::*;

  // config
  logic [ORDER_W-1:0] grid_order_r;
  dir_t               start_direction_r;
  logic               rotation_r;

  // step stage
  logic s1_valid_r, s1_restart_r;
  logic s1_go, in_accept;

  // walk state
  logic [ORDER_W-1:0] cur_row_r, cur_col_r, cur_row_nxt, cur_col_nxt;
  dir_t               heading_r, heading_nxt;
  logic [SEQ_W-1:0]   step_count_r, step_count_nxt;
  logic [SUM_W-1:0]   diag_total_r, diag_total_nxt;
  logic               walk_active_r, walk_active_nxt;

  // result register
  logic               out_valid_r;
  logic [ORDER_W-1:0] out_row_r, out_col_r;
  logic [SEQ_W-1:0]   out_seq_value_r;
  logic [SUM_W-1:0]   out_diag_sum_r;
  logic               out_last_r, out_order_error_r;
  logic               res_error;
  logic               res_last;

  // datapath
  logic [ORDER_W-1:0]      half_n;
  logic [SEQ_W-1:0]        nn;
  logic signed [OFF_W-1:0] dr, dc, adr, adc, ndr, ndc, nsum;
  logic [ORDER_W-1:0]      ring_k;
  logic [ORDER_W:0]        side;
  logic [RING_W-1:0]       ring_last;
  dir_t                    mv;
  logic [ORDER_W:0]        rc_sum;
  logic                    on_diag;

  assign in_accept = in_valid && !in_stall;
  assign s1_go     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_go;

  assign half_n = {1'b0, grid_order_r[ORDER_W-1:1]};
  assign nn     = SEQ_W'(grid_order_r) * SEQ_W'(grid_order_r);

  assign dr  = OFF_W'(signed'({2'b00, cur_row_r})) - OFF_W'(signed'({2'b00, half_n}));
  assign dc  = OFF_W'(signed'({2'b00, cur_col_r})) - OFF_W'(signed'({2'b00, half_n}));
  assign adr = (dr < 0) ? -dr : dr;
  assign adc = (dc < 0) ? -dc : dc;
  assign ring_k    = (adr > adc) ? adr[ORDER_W-1:0] : adc[ORDER_W-1:0];
  assign side      = {ring_k, 1'b1};
  assign ring_last = RING_W'(side) * RING_W'(side);

  always_comb begin
    cur_row_nxt     = cur_row_r;
    cur_col_nxt     = cur_col_r;
    heading_nxt     = heading_r;
    step_count_nxt  = step_count_r;
    diag_total_nxt  = diag_total_r;
    walk_active_nxt = walk_active_r;
    res_error       = 1'b0;
    mv              = heading_r;
    ndr             = dr;
    ndc             = dc;
    nsum            = '0;
    if (!grid_order_r[0]) begin
      res_error       = 1'b1;
      walk_active_nxt = 1'b0;
    end else if (s1_restart_r || !walk_active_r || step_count_r >= nn) begin
      cur_row_nxt     = half_n;
      cur_col_nxt     = half_n;
      heading_nxt     = start_direction_r;
      step_count_nxt  = SEQ_W'(1);
      walk_active_nxt = 1'b1;
    end else begin
      if ({2'b00, step_count_r} != ring_last) begin
        mv = turn_dir(heading_r, rotation_r);
      end
      ndr  = dr + dir_drow(mv);
      ndc  = dc + dir_dcol(mv);
      nsum = ndr + ndc;
      if ({2'b00, step_count_r} != ring_last) begin
        if (ndr == ndc) begin
          if (rotation_r) heading_nxt = (ndr > 0) ? DIR_RIGHT : DIR_LEFT;
          else            heading_nxt = (ndr > 0) ? DIR_DOWN  : DIR_UP;
        end else if (nsum == 0) begin
          if (rotation_r) heading_nxt = (ndr > ndc) ? DIR_DOWN : DIR_UP;
          else            heading_nxt = (ndr > ndc) ? DIR_LEFT : DIR_RIGHT;
        end
      end
      cur_row_nxt    = cur_row_r + ORDER_W'(dir_drow(mv));
      cur_col_nxt    = cur_col_r + ORDER_W'(dir_dcol(mv));
      step_count_nxt = step_count_r + SEQ_W'(1);
    end
    if (!res_error) begin
      diag_total_nxt = (step_count_nxt == SEQ_W'(1) && heading_nxt == start_direction_r &&
                        (s1_restart_r || !walk_active_r || step_count_r >= nn))
                       ? '0 : diag_total_r;
      if (on_diag) diag_total_nxt = diag_total_nxt + SUM_W'(step_count_nxt);
    end
  end

  assign rc_sum  = {1'b0, cur_row_nxt} + {1'b0, cur_col_nxt};
  assign on_diag = (cur_row_nxt == cur_col_nxt) ||
                   (rc_sum == {1'b0, grid_order_r - ORDER_W'(1)});
  assign res_last = (step_count_nxt == nn);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_order_r      <= ORDER_W'(1);
      start_direction_r <= DIR_RIGHT;
      rotation_r        <= 1'b0;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      cur_row_r         <= '0;
      cur_col_r         <= '0;
      heading_r         <= DIR_RIGHT;
      step_count_r      <= '0;
      diag_total_r      <= '0;
      walk_active_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_ORDER:      grid_order_r      <= cfg_data;
          CFG_START_DIRECTION: start_direction_r <= dir_t'(cfg_data[1:0]);
          CFG_ROTATION:        rotation_r        <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_accept)  s1_valid_r <= 1'b1;
      else if (s1_go) s1_valid_r <= 1'b0;
      out_valid_r <= s1_go || (out_valid_r && out_stall);
      if (s1_go) begin
        cur_row_r     <= cur_row_nxt;
        cur_col_r     <= cur_col_nxt;
        heading_r     <= heading_nxt;
        step_count_r  <= step_count_nxt;
        diag_total_r  <= diag_total_nxt;
        walk_active_r <= walk_active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_restart_r <= in_restart;
    if (s1_go) begin
      out_row_r         <= res_error ? '0 : cur_row_nxt;
      out_col_r         <= res_error ? '0 : cur_col_nxt;
      out_seq_value_r   <= res_error ? '0 : step_count_nxt;
      out_diag_sum_r    <= res_error ? '0 : diag_total_nxt;
      out_last_r        <= res_error ? 1'b0 : res_last;
      out_order_error_r <= res_error;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_seq_value   = out_seq_value_r;
  assign out_diag_sum    = out_diag_sum_r;
  assign out_last        = out_last_r;
  assign out_order_error = out_order_error_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_order_error_r |->
      out_row_r == '0 && out_col_r == '0 && out_seq_value_r == '0 &&
      out_diag_sum_r == '0 && !out_last_r)
    else $error("order error result with nonzero fields");

  a_hold_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r && $stable(step_count_r))
    else $error("pending item lost or walk advanced under stall");

  a_active: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && grid_order_r[0] |=> walk_active_r && out_valid_r && !out_order_error_r)
    else $error("good order did not leave walk active");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_restart_r && grid_order_r[0] |=>
      out_seq_value_r == SEQ_W'(1) && out_diag_sum_r == SUM_W'(1))
    else $error("restart did not emit centre");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_seq_value_r == nn)
    else $error("last flag on wrong value");

endmodule
